### src/gha_pkg.sv
// Shared types and constants of the gated assignment solver.
// Used by gha_cell and gated_hungarian_assignment_top; depends on nothing else.
package gha_pkg;

    localparam int MAX_TRACKS     = 16;
    localparam int MAX_DETECTIONS = 16;
    localparam int NCOL           = MAX_TRACKS + MAX_DETECTIONS;
    localparam int NREC           = NCOL + 1;

    localparam int IDX_W  = $clog2(NREC);
    localparam int ROW_W  = $clog2(MAX_TRACKS + 1);
    localparam int TR_W   = $clog2(MAX_TRACKS);
    localparam int DET_W  = $clog2(MAX_DETECTIONS);
    localparam int NDET_W = $clog2(MAX_DETECTIONS + 1);
    localparam int COST_W = 32;
    localparam int VAL_W  = 48;
    localparam int PROD_W = COST_W + ROW_W + 1;

    localparam logic signed [VAL_W-1:0] SLACK_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [COST_W-1:0] Q_ONE = 32'd65536;

    // Everything the solver keeps about one column travels in one record.
    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic [ROW_W-1:0]        owner;
        logic [IDX_W-1:0]        pred;
        logic signed [VAL_W-1:0] pot;
        logic signed [VAL_W-1:0] slack;
        logic                    vis;
    } col_rec_t;

endpackage

### src/gha_cell.sv
// One stage of the column ring: holds one column record and passes it on.
// Depends on gha_pkg for the record type.
module gha_cell
(
    input  logic              clk,
    input  logic              en,
    input  gha_pkg::col_rec_t rec_in,
    output gha_pkg::col_rec_t rec_out
);

    gha_pkg::col_rec_t rec_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rec_reg <= rec_in;
        end
    end

    assign rec_out = rec_reg;

endmodule

### src/gated_hungarian_assignment_top.sv
// Top level of the gated track-to-detection assignment solver.
// Depends on gha_pkg and instantiates the gha_cell ring.
//
// Usage: set unassign_cost, num_tracks and num_detections over the APB port
// while the block is idle. Load cost entries with start; a transfer is taken
// on a clock edge with start high and busy low, one per cycle while loading.
// The entry flagged last_entry is stored and starts the solve; busy stays high
// until all results are out. With zero tracks no solve runs and busy stays low.
// Every entry a solve reads must have been loaded since reset.
// The solve keeps one record per column (dummy columns included) in a ring of
// 33 cells that rotates one place per cycle except in the RDRP, WTRP, CPRE and
// EMIT states; all column work happens at the ring head. Order: a clear pass,
// per track a row-init pass, per search step a row-potential read, a scan pass
// and an update pass, an augment pass per augmenting column, then flush, collect.
// Results come one per cycle, on result_valid for exactly one cycle each, in
// track order; last_result marks the final track. The receiver cannot stall.
// Reset returns the configuration registers to their reset values and the solver to idle.
module gated_hungarian_assignment_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  track_index,
    input  logic [3:0]  detection_index,
    input  logic [31:0] cost_value,
    input  logic        cost_not_finite,
    input  logic        last_entry,
    output logic        result_valid,
    output logic [3:0]  out_track,
    output logic [3:0]  out_detection,
    output logic        assigned,
    output logic        last_result
);

    localparam logic [1:0] REG_UNASSIGN   = 2'd0;
    localparam logic [1:0] REG_NUM_TRACKS = 2'd1;
    localparam logic [1:0] REG_NUM_DETS   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLR, ST_RINIT, ST_RDRP, ST_WTRP, ST_SCAN,
        ST_UPD, ST_AUG, ST_FLUSH, ST_CPRE, ST_COLL, ST_EMIT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [31:0] unassign_reg;
    logic [4:0]  num_tracks_reg;
    logic [4:0]  num_dets_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unassign_reg   <= 32'd65536;
            num_tracks_reg <= '0;
            num_dets_reg   <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_UNASSIGN:   unassign_reg   <= pwdata;
                REG_NUM_TRACKS: num_tracks_reg <= pwdata[4:0];
                REG_NUM_DETS:   num_dets_reg   <= pwdata[4:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_UNASSIGN:   prdata = unassign_reg;
            REG_NUM_TRACKS: prdata = {27'd0, num_tracks_reg};
            REG_NUM_DETS:   prdata = {27'd0, num_dets_reg};
            default:        prdata = '0;
        endcase
    end

    // Solve parameters latched at the start of a solve.
    logic [gha_pkg::ROW_W-1:0]         ntr_reg;
    logic [gha_pkg::NDET_W-1:0]        ndet_reg;
    logic [gha_pkg::IDX_W-1:0]         ncol_reg;
    logic [gha_pkg::COST_W-1:0]        u_reg;
    logic [gha_pkg::PROD_W-1:0]        prod_reg;
    logic signed [gha_pkg::VAL_W-1:0]  forbid_reg;

    logic [4:0] ntr_sat;
    logic [4:0] ndet_sat;

    assign ntr_sat  = (num_tracks_reg > 5'(gha_pkg::MAX_TRACKS)) ?
                      5'(gha_pkg::MAX_TRACKS) : num_tracks_reg;
    assign ndet_sat = (num_dets_reg > 5'(gha_pkg::MAX_DETECTIONS)) ?
                      5'(gha_pkg::MAX_DETECTIONS) : num_dets_reg;

    // Solver control registers.
    logic [gha_pkg::IDX_W-1:0]        cnt_reg;
    logic [gha_pkg::ROW_W-1:0]        row_reg;
    logic [gha_pkg::ROW_W-1:0]        cur_reg;
    logic [gha_pkg::IDX_W-1:0]        col_reg;
    logic [gha_pkg::IDX_W-1:0]        next_reg;
    logic signed [gha_pkg::VAL_W-1:0] delta_reg;
    logic signed [gha_pkg::VAL_W-1:0] rpcur_reg;
    logic [gha_pkg::ROW_W-1:0]        own_n_reg;
    logic [gha_pkg::IDX_W-1:0]        pred_n_reg;
    logic [gha_pkg::IDX_W-1:0]        aj_reg;
    logic [gha_pkg::IDX_W-1:0]        ap_reg;
    logic [gha_pkg::ROW_W-1:0]        own_p_reg;
    logic [gha_pkg::IDX_W-1:0]        pred_p_reg;
    logic                             pend_valid_reg;
    logic [gha_pkg::IDX_W-1:0]        pend_col_reg;
    logic [gha_pkg::ROW_W-1:0]        pend_val_reg;
    logic [gha_pkg::TR_W-1:0]         k_reg;

    logic [gha_pkg::DET_W-1:0] res_det_reg [gha_pkg::MAX_TRACKS];
    logic                      res_as_reg  [gha_pkg::MAX_TRACKS];

    logic                      result_valid_reg;
    logic [3:0]                out_track_reg;
    logic [3:0]                out_detection_reg;
    logic                      assigned_reg;
    logic                      last_result_reg;

    // Column ring.
    gha_pkg::col_rec_t ring [gha_pkg::NREC];
    gha_pkg::col_rec_t head_next;
    gha_pkg::col_rec_t h;
    gha_pkg::col_rec_t nh;
    logic              ring_en;

    assign ring_en = (state_reg == ST_CLR) || (state_reg == ST_RINIT) ||
                     (state_reg == ST_SCAN) || (state_reg == ST_UPD) ||
                     (state_reg == ST_AUG) || (state_reg == ST_FLUSH) ||
                     (state_reg == ST_COLL);

    genvar gi;
    generate
        for (gi = 0; gi < gha_pkg::NREC; gi++)
        begin : g_ring
            if (gi == gha_pkg::NREC - 1)
            begin : g_tail
                gha_cell u_cell (.clk(clk), .en(ring_en), .rec_in(head_next),
                                 .rec_out(ring[gi]));
            end
            else
            begin : g_mid
                gha_cell u_cell (.clk(clk), .en(ring_en), .rec_in(ring[gi+1]),
                                 .rec_out(ring[gi]));
            end
        end
    endgenerate

    assign h  = ring[0];
    // The record that sits at the head in the coming cycle.
    assign nh = ring_en ? ring[1] : ring[0];

    // Cost store: value plus non-finite flag, registered read.
    logic [gha_pkg::COST_W:0]          cost_mem [gha_pkg::MAX_TRACKS * gha_pkg::MAX_DETECTIONS];
    logic [gha_pkg::COST_W:0]          cm_rd;
    logic [gha_pkg::TR_W+gha_pkg::DET_W-1:0] cm_raddr;
    logic [gha_pkg::ROW_W-1:0]         cm_row;
    logic [gha_pkg::IDX_W-1:0]         cm_col;
    logic                              load_acc;

    assign load_acc = start && !busy;
    assign cm_row   = ((state_reg == ST_CPRE) || (state_reg == ST_COLL)) ?
                      nh.owner - 1'b1 : cur_reg - 1'b1;
    assign cm_col   = nh.idx - 1'b1;
    assign cm_raddr = {cm_row[gha_pkg::TR_W-1:0], cm_col[gha_pkg::DET_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (load_acc)
        begin
            cost_mem[{track_index, detection_index}] <= {cost_not_finite, cost_value};
        end
        cm_rd <= cost_mem[cm_raddr];
    end

    // Row potentials: one read port and one write port, registered read.
    logic signed [gha_pkg::VAL_W-1:0] rp_mem [gha_pkg::MAX_TRACKS + 1];
    logic signed [gha_pkg::VAL_W-1:0] rp_rd;
    logic [gha_pkg::ROW_W-1:0]        rp_raddr;
    logic                             in_cols;

    assign rp_raddr = (state_reg == ST_RDRP) ? cur_reg : nh.owner;
    assign in_cols  = (h.idx <= ncol_reg);

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_CLR) && (cnt_reg < gha_pkg::IDX_W'(gha_pkg::MAX_TRACKS + 1)))
        begin
            rp_mem[cnt_reg[gha_pkg::ROW_W-1:0]] <= '0;
        end
        else if ((state_reg == ST_UPD) && in_cols && h.vis)
        begin
            rp_mem[h.owner] <= rp_rd + delta_reg;
        end
        rp_rd <= rp_mem[rp_raddr];
    end

    // Head processing.
    logic signed [gha_pkg::VAL_W-1:0] ce;
    logic signed [gha_pkg::VAL_W-1:0] r_val;
    logic                             scan_ok;
    logic                             cand;
    logic                             cost_ok;

    always_comb
    begin
        cost_ok = !cm_rd[gha_pkg::COST_W] && (cm_rd[gha_pkg::COST_W-1:0] < u_reg);
        if (h.idx > gha_pkg::IDX_W'(ndet_reg))
        begin
            ce = gha_pkg::VAL_W'(u_reg);
        end
        else if (cost_ok)
        begin
            ce = gha_pkg::VAL_W'(cm_rd[gha_pkg::COST_W-1:0]);
        end
        else
        begin
            ce = forbid_reg;
        end
        r_val   = ce - rpcur_reg - h.pot;
        scan_ok = (h.idx != col_reg) && (h.idx != '0) && in_cols && !h.vis;

        head_next = h;
        if (pend_valid_reg && (h.idx == pend_col_reg))
        begin
            head_next.owner = pend_val_reg;
        end
        unique case (state_reg)
            ST_CLR:
            begin
                head_next     = '0;
                head_next.idx = cnt_reg;
            end
            ST_RINIT:
            begin
                head_next.slack = gha_pkg::SLACK_MAX;
                head_next.vis   = 1'b0;
                if (h.idx == '0)
                begin
                    head_next.owner = row_reg;
                end
            end
            ST_SCAN:
            begin
                if (h.idx == col_reg)
                begin
                    head_next.vis = 1'b1;
                end
                else if (scan_ok && (r_val < h.slack))
                begin
                    head_next.slack = r_val;
                    head_next.pred  = col_reg;
                end
            end
            ST_UPD:
            begin
                if (in_cols)
                begin
                    if (h.vis)
                    begin
                        head_next.pot = h.pot - delta_reg;
                    end
                    else
                    begin
                        head_next.slack = h.slack - delta_reg;
                    end
                end
            end
            default: ;
        endcase
        cand = scan_ok && (head_next.slack < delta_reg);
    end

    logic                      pass_end;
    logic [gha_pkg::ROW_W-1:0] cap_own_n;
    logic [gha_pkg::IDX_W-1:0] cap_pred_n;
    logic [gha_pkg::ROW_W-1:0] cap_own_p;
    logic [gha_pkg::IDX_W-1:0] cap_pred_p;
    logic                      coll_hit;

    assign pass_end   = (cnt_reg == gha_pkg::IDX_W'(gha_pkg::NREC - 1));
    assign cap_own_n  = (h.idx == next_reg) ? h.owner : own_n_reg;
    assign cap_pred_n = (h.idx == next_reg) ? h.pred  : pred_n_reg;
    assign cap_own_p  = (h.idx == ap_reg)   ? h.owner : own_p_reg;
    assign cap_pred_p = (h.idx == ap_reg)   ? h.pred  : pred_p_reg;
    assign coll_hit   = (h.owner != '0) && (h.idx != '0) &&
                        (h.idx <= gha_pkg::IDX_W'(ndet_reg)) && cost_ok;

    logic [gha_pkg::ROW_W-1:0] own_m1;
    logic [gha_pkg::IDX_W-1:0] idx_m1;

    assign own_m1 = h.owner - 1'b1;
    assign idx_m1 = h.idx - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (ring_en)
            begin
                cnt_reg <= pass_end ? '0 : cnt_reg + 1'b1;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (load_acc && last_entry)
                    begin
                        ntr_reg  <= ntr_sat;
                        ndet_reg <= ndet_sat;
                        ncol_reg <= gha_pkg::IDX_W'(ntr_sat) + gha_pkg::IDX_W'(ndet_sat);
                        u_reg    <= (unassign_reg == '0) ? 32'd1 : unassign_reg;
                        cnt_reg  <= '0;
                        if (ntr_sat != '0)
                        begin
                            state_reg <= ST_CLR;
                        end
                    end
                end
                ST_CLR:
                begin
                    prod_reg <= gha_pkg::PROD_W'(u_reg) *
                                gha_pkg::PROD_W'({1'b0, ntr_reg} + 1'b1);
                    forbid_reg <= (gha_pkg::VAL_W'(prod_reg) >
                                   gha_pkg::VAL_W'(u_reg) + gha_pkg::VAL_W'(gha_pkg::Q_ONE)) ?
                                  gha_pkg::VAL_W'(prod_reg) :
                                  gha_pkg::VAL_W'(u_reg) + gha_pkg::VAL_W'(gha_pkg::Q_ONE);
                    for (int i = 0; i < gha_pkg::MAX_TRACKS; i++)
                    begin
                        res_as_reg[i] <= 1'b0;
                    end
                    if (pass_end)
                    begin
                        row_reg        <= gha_pkg::ROW_W'(1);
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_RINIT;
                    end
                end
                ST_RINIT:
                begin
                    if (pass_end)
                    begin
                        pend_valid_reg <= 1'b0;
                        col_reg        <= '0;
                        cur_reg        <= row_reg;
                        state_reg      <= ST_RDRP;
                    end
                end
                ST_RDRP:
                begin
                    state_reg <= ST_WTRP;
                end
                ST_WTRP:
                begin
                    rpcur_reg <= rp_rd;
                    delta_reg <= gha_pkg::SLACK_MAX;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (cand)
                    begin
                        delta_reg <= head_next.slack;
                        next_reg  <= h.idx;
                    end
                    if (pass_end)
                    begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    own_n_reg  <= cap_own_n;
                    pred_n_reg <= cap_pred_n;
                    if (pass_end)
                    begin
                        col_reg <= next_reg;
                        if (cap_own_n != '0)
                        begin
                            cur_reg   <= cap_own_n;
                            state_reg <= ST_RDRP;
                        end
                        else
                        begin
                            aj_reg         <= next_reg;
                            ap_reg         <= cap_pred_n;
                            pend_valid_reg <= 1'b0;
                            state_reg      <= ST_AUG;
                        end
                    end
                end
                ST_AUG:
                begin
                    own_p_reg  <= cap_own_p;
                    pred_p_reg <= cap_pred_p;
                    if (pass_end)
                    begin
                        // Column aj takes the owner of its predecessor on the next pass.
                        pend_col_reg   <= aj_reg;
                        pend_val_reg   <= cap_own_p;
                        pend_valid_reg <= 1'b1;
                        aj_reg         <= ap_reg;
                        ap_reg         <= cap_pred_p;
                        if (ap_reg == '0)
                        begin
                            if (row_reg == ntr_reg)
                            begin
                                state_reg <= ST_FLUSH;
                            end
                            else
                            begin
                                row_reg   <= row_reg + 1'b1;
                                state_reg <= ST_RINIT;
                            end
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (pass_end)
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_CPRE;
                    end
                end
                ST_CPRE:
                begin
                    state_reg <= ST_COLL;
                end
                ST_COLL:
                begin
                    if (coll_hit)
                    begin
                        res_det_reg[own_m1[gha_pkg::TR_W-1:0]] <= idx_m1[gha_pkg::DET_W-1:0];
                        res_as_reg[own_m1[gha_pkg::TR_W-1:0]]  <= 1'b1;
                    end
                    if (pass_end)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    result_valid_reg  <= 1'b1;
                    out_track_reg     <= 4'(k_reg);
                    out_detection_reg <= res_as_reg[k_reg] ? 4'(res_det_reg[k_reg]) : 4'd0;
                    assigned_reg      <= res_as_reg[k_reg];
                    last_result_reg   <= ({1'b0, k_reg} == ntr_reg - 1'b1);
                    k_reg             <= k_reg + 1'b1;
                    if ({1'b0, k_reg} == ntr_reg - 1'b1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_valid  = result_valid_reg;
    assign out_track     = out_track_reg;
    assign out_detection = out_detection_reg;
    assign assigned      = assigned_reg;
    assign last_result   = last_result_reg;

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_result |=> !result_valid)
        else $error("result stream continued after the final track");

    a_track_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_result |=>
            result_valid && (out_track == 4'($past(out_track) + 1'b1)))
        else $error("results left track order");

    a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) || (state_reg == ST_UPD) |-> (h.idx == cnt_reg))
        else $error("ring head out of step with the pass counter");

    a_solve_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load_acc && last_entry && (ntr_sat != '0) |=> busy)
        else $error("solve did not start on the final load transfer");

endmodule
